### design/ffgp_pkg.sv
// Shared constants and types for the first-fit grid placer.
// No dependencies; compile before the interfaces and the top level.
package ffgp_pkg;

  // Field widths of the rectangle and placement beats.
  localparam int DIM_W   = 5;
  localparam int COORD_W = 4;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Default grid storage size.
  localparam int DEFAULT_MAX_COLUMNS = 16;
  localparam int DEFAULT_MAX_ROWS    = 16;

  // Width for internal row/column counters and compares (holds 64 + 31).
  localparam int CMP_W = 8;

  // Configuration register map.
  localparam int REG_IDX_W = 1;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_GRID_WIDTH  = 1'd0;
  localparam reg_idx_t REG_GRID_HEIGHT = 1'd1;

  localparam dim_t GRID_RESET = 5'd8;

endpackage

### design/ffgp_rect_if.sv
// Rectangle request channel: valid/ready with clear flag and size.
// Depends on ffgp_pkg for field types.
interface ffgp_rect_if;
  logic            valid;
  logic            ready;
  logic            clear_first;
  ffgp_pkg::dim_t  rect_width;
  ffgp_pkg::dim_t  rect_height;

  modport source (output valid, clear_first, rect_width, rect_height, input ready);
  modport sink   (input valid, clear_first, rect_width, rect_height, output ready);
endinterface

### design/ffgp_place_if.sv
// Placement result channel: valid/ready with placed flag and anchor.
// Depends on ffgp_pkg for field types.
interface ffgp_place_if;
  logic              valid;
  logic              ready;
  logic              placed;
  ffgp_pkg::coord_t  cell_x;
  ffgp_pkg::coord_t  cell_y;

  modport source (output valid, placed, cell_x, cell_y, input ready);
  modport sink   (input valid, placed, cell_x, cell_y, output ready);
endinterface

### design/first_fit_grid_placer.sv
// First-fit rectangle placer on an occupancy grid kept in a one-port-read RAM.
// Steps: accept, row scan (one RAM row per cycle), mark (read-modify-write per
// row), then result; zero-size, oversize and empty-grid cases skip scan and mark.
// One rectangle at a time: the next is accepted only once the result is loaded.
// Reset: rst (synchronous, active high) frees all cells via per-row valid bits,
// sets grid size to 8 x 8 and empties the result register; no clearing pass.
module first_fit_grid_placer #(
  parameter int MAX_COLUMNS = ffgp_pkg::DEFAULT_MAX_COLUMNS,
  parameter int MAX_ROWS    = ffgp_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  ffgp_pkg::reg_idx_t  cfg_index,
  input  ffgp_pkg::dim_t      cfg_data,
  ffgp_rect_if.sink           rect_in,
  ffgp_place_if.source        place_out
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = ffgp_pkg::CMP_W;
  localparam int DW     = ffgp_pkg::DIM_W;

  typedef logic [CW-1:0] cnt_t;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [DW-1:0] RUN_MAX = {DW{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  ffgp_pkg::dim_t grid_width;
  ffgp_pkg::dim_t grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= ffgp_pkg::GRID_RESET;
      grid_height <= ffgp_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ffgp_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        ffgp_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the configured grid to what the storage holds.
  cnt_t gw_sat;
  cnt_t gh_sat;
  assign gw_sat = (CW'(grid_width) > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(grid_width);
  assign gh_sat = (CW'(grid_height) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(grid_height);

  // ---------------------------------------------------------------------------
  // Occupancy RAM: one row of MAX_COLUMNS bits per entry, registered read.
  // Each row has a valid bit; an invalid row reads as all free, so reset and
  // clear_first free the whole grid with no clearing pass.
  // ---------------------------------------------------------------------------
  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_vld;

  logic                   mem_re;
  logic [ROW_AW-1:0]      mem_raddr;
  logic [MAX_COLUMNS-1:0] mem_rdata;
  logic                   mem_rvld;
  logic [MAX_COLUMNS-1:0] rdata_eff;

  logic                   mem_we;
  logic [ROW_AW-1:0]      mem_waddr;
  logic [MAX_COLUMNS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
      mem_rvld  <= row_vld[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign rdata_eff = mem_rvld ? mem_rdata : '0;

  // ---------------------------------------------------------------------------
  // Control and working registers
  // ---------------------------------------------------------------------------
  logic [1:0] state;
  cnt_t       gw_q;
  cnt_t       gh_q;
  cnt_t       w_q;
  cnt_t       h_q;
  cnt_t       rd_row;    // next row to fetch during the scan
  logic       rd_pend;   // a scan row returns this cycle
  cnt_t       rq_row;    // index of the returning scan row
  cnt_t       x_q;
  cnt_t       y_q;
  logic       res_placed;
  cnt_t       mk_row;    // next row to fetch for marking
  cnt_t       mk_left;   // mark rows still to fetch
  logic       wr_pend;   // a mark row returns and is written back this cycle
  cnt_t       wr_row;

  // Vertical free-run length per column, ending at the returning row.
  logic [DW-1:0] run      [MAX_COLUMNS];
  logic [DW-1:0] run_next [MAX_COLUMNS];

  logic                   out_valid;
  logic                   out_placed;
  ffgp_pkg::coord_t       out_x;
  ffgp_pkg::coord_t       out_y;

  logic                   accept;
  logic                   scan_re;
  logic                   mark_re;
  logic                   hit;
  logic                   any_fit;
  cnt_t                   hit_x;
  logic [MAX_COLUMNS-1:0] col_ok;
  logic [MAX_COLUMNS-1:0] fit;
  logic [MAX_COLUMNS-1:0] place_mask;
  logic                   out_free;
  cnt_t                   anchor_y;

  assign rect_in.ready = (state == S_IDLE);
  assign accept        = rect_in.valid && rect_in.ready;
  assign out_free      = !out_valid || place_out.ready;

  // Column c can hold an anchor row rq_row-h+1 if h free rows end here.
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (rdata_eff[c]) begin
        run_next[c] = '0;
      end else if (run[c] == RUN_MAX) begin
        run_next[c] = RUN_MAX;
      end else begin
        run_next[c] = run[c] + 1'b1;
      end
      col_ok[c] = (CW'(run_next[c]) >= h_q);
    end
  end

  // Horizontal window check at every column, then take the lowest anchor.
  always_comb begin
    for (int x = 0; x < MAX_COLUMNS; x++) begin
      fit[x] = ((CW'(x) + w_q) <= gw_q);
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        if ((i >= x) && (CW'(i) < CW'(x) + w_q) && !col_ok[i]) begin
          fit[x] = 1'b0;
        end
      end
    end
    any_fit = 1'b0;
    hit_x   = '0;
    for (int x = MAX_COLUMNS - 1; x >= 0; x--) begin
      if (fit[x]) begin
        any_fit = 1'b1;
        hit_x   = CW'(x);
      end
    end
  end

  assign hit      = (state == S_SCAN) && rd_pend && ((rq_row + 1'b1) >= h_q) && any_fit;
  assign anchor_y = rq_row + 1'b1 - h_q;

  // RAM port steering: scan fetches stop once a fit is found.
  assign scan_re   = (state == S_SCAN) && (rd_row < gh_q) && !hit;
  assign mark_re   = (state == S_MARK) && (mk_left != '0);
  assign mem_re    = scan_re || mark_re;
  assign mem_raddr = mark_re ? mk_row[ROW_AW-1:0] : rd_row[ROW_AW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      place_mask[i] = (CW'(i) >= x_q) && (CW'(i) < x_q + w_q);
    end
  end

  assign mem_we    = wr_pend;
  assign mem_waddr = wr_row[ROW_AW-1:0];
  assign mem_wdata = rdata_eff | place_mask;

  // Run counters restart with every rectangle.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        run[c] <= '0;
      end
    end else if ((state == S_SCAN) && rd_pend) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        run[c] <= run_next[c];
      end
    end
  end

  // Payload registers: latched at accept or on the way, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      gw_q <= gw_sat;
      gh_q <= gh_sat;
      w_q  <= CW'(rect_in.rect_width);
      h_q  <= CW'(rect_in.rect_height);
      x_q  <= '0;
      y_q  <= '0;
    end else if (hit) begin
      x_q <= hit_x;
      y_q <= anchor_y;
    end
    if (scan_re) begin
      rq_row <= rd_row;
    end
    if (mark_re) begin
      wr_row <= mk_row;
    end
    if ((state == S_DONE) && out_free) begin
      out_placed <= res_placed;
      out_x      <= x_q[ffgp_pkg::COORD_W-1:0];
      out_y      <= y_q[ffgp_pkg::COORD_W-1:0];
    end
  end

  // Result valid: load from the done state, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (place_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_vld    <= '0;
      rd_row     <= '0;
      rd_pend    <= 1'b0;
      mk_row     <= '0;
      mk_left    <= '0;
      wr_pend    <= 1'b0;
      res_placed <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld[mem_waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            // Drop all occupancy at the start of a new packing run.
            if (rect_in.clear_first) begin
              row_vld <= '0;
            end
            rd_row  <= '0;
            rd_pend <= 1'b0;
            wr_pend <= 1'b0;
            if ((gw_sat == '0) || (gh_sat == '0)) begin
              res_placed <= 1'b0;
              state      <= S_DONE;
            end else if ((rect_in.rect_width == '0) || (rect_in.rect_height == '0)) begin
              // Empty rectangle sits at the origin and marks nothing.
              res_placed <= 1'b1;
              state      <= S_DONE;
            end else if ((CW'(rect_in.rect_width) > gw_sat) ||
                         (CW'(rect_in.rect_height) > gh_sat)) begin
              res_placed <= 1'b0;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (scan_re) begin
            rd_row <= rd_row + 1'b1;
          end
          // No fetch goes out on a hit, so this also clears the pending flag.
          rd_pend <= scan_re;
          if (hit) begin
            // Mark the h rows from the anchor row down.
            mk_row  <= anchor_y;
            mk_left <= h_q;
            state   <= S_MARK;
          end else if (rd_pend && (rq_row == gh_q - 1'b1)) begin
            // Last row seen without a fit.
            res_placed <= 1'b0;
            state      <= S_DONE;
          end
        end

        S_MARK: begin
          if (mark_re) begin
            mk_row  <= mk_row + 1'b1;
            mk_left <= mk_left - 1'b1;
          end
          wr_pend <= mark_re;
          if (wr_pend && !mark_re) begin
            res_placed <= 1'b1;
            state      <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign place_out.valid  = out_valid;
  assign place_out.placed = out_placed;
  assign place_out.cell_x = out_x;
  assign place_out.cell_y = out_y;

endmodule

### test/tb_first_fit_grid_placer.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_grid_placer: a directed table, then random packing runs.
// Depends on ffgp_pkg and the ffgp_rect_if / ffgp_place_if interfaces of the design.
module tb_first_fit_grid_placer;

  typedef ffgp_pkg::dim_t     dim_t;
  typedef ffgp_pkg::coord_t   coord_t;
  typedef ffgp_pkg::reg_idx_t reg_idx_t;

  localparam reg_idx_t REG_GRID_WIDTH  = ffgp_pkg::REG_GRID_WIDTH;
  localparam reg_idx_t REG_GRID_HEIGHT = ffgp_pkg::REG_GRID_HEIGHT;
  localparam dim_t     GRID_RESET      = ffgp_pkg::GRID_RESET;

  localparam int NCOLS        = ffgp_pkg::DEFAULT_MAX_COLUMNS;
  localparam int NROWS        = ffgp_pkg::DEFAULT_MAX_ROWS;
  localparam int RANDOM_RECTS = 1350;
  // Watchdog limit on the whole run, counted over all beats rather than per beat.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic   placed;
    coord_t x;
    coord_t y;
  } placement_t;

  typedef enum logic {ROW_RECT, ROW_CFG} row_kind_t;

  // One row of the directed table. Register rows carry the value in w.
  typedef struct packed {
    row_kind_t  kind;
    reg_idx_t   sel;
    logic       clr;
    dim_t       w;
    dim_t       h;
    logic       typed;
    placement_t want;
  } stim_row_t;

  localparam placement_t MISS   = '{1'b0, 4'd0, 4'd0};
  localparam placement_t ORIGIN = '{1'b1, 4'd0, 4'd0};

  // Directed walk, starting from the 8 x 8 reset grid. Rows with typed = 0
  // are checked against the placement predictor.
  localparam stim_row_t DIRECTED [28] = '{
    '{ROW_RECT, REG_GRID_WIDTH,  1'b1, 5'd0,  5'd0,  1'b1, ORIGIN},  // zero size, clear
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd8,  5'd8,  1'b1, ORIGIN},  // fills the grid
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd1,  1'b1, MISS},    // grid full
    '{ROW_RECT, REG_GRID_WIDTH,  1'b1, 5'd9,  5'd1,  1'b1, MISS},    // wider than grid
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd3,  5'd2,  1'b1, ORIGIN},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd3,  5'd2,  1'b1, '{1'b1, 4'd3, 4'd0}},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd3,  5'd2,  1'b0, MISS},    // wraps to next rows
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd0,  1'b1, ORIGIN},  // zero height
    '{ROW_CFG,  REG_GRID_WIDTH,  1'b0, 5'd16, 5'd0,  1'b0, MISS},
    '{ROW_CFG,  REG_GRID_HEIGHT, 1'b0, 5'd16, 5'd0,  1'b0, MISS},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b1, 5'd16, 5'd16, 1'b1, ORIGIN},  // whole grid
    '{ROW_RECT, REG_GRID_WIDTH,  1'b1, 5'd16, 5'd1,  1'b1, ORIGIN},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd15, 1'b0, MISS},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd31, 5'd1,  1'b1, MISS},    // widest field value
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd31, 1'b1, MISS},
    '{ROW_CFG,  REG_GRID_WIDTH,  1'b0, 5'd31, 5'd0,  1'b0, MISS},    // saturates to 16
    '{ROW_CFG,  REG_GRID_HEIGHT, 1'b0, 5'd17, 5'd0,  1'b0, MISS},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b1, 5'd16, 5'd16, 1'b1, ORIGIN},
    '{ROW_CFG,  REG_GRID_WIDTH,  1'b0, 5'd0,  5'd0,  1'b0, MISS},    // empty grid
    '{ROW_RECT, REG_GRID_WIDTH,  1'b1, 5'd0,  5'd0,  1'b1, MISS},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd1,  1'b1, MISS},
    '{ROW_CFG,  REG_GRID_WIDTH,  1'b0, 5'd1,  5'd0,  1'b0, MISS},    // single cell
    '{ROW_CFG,  REG_GRID_HEIGHT, 1'b0, 5'd1,  5'd0,  1'b0, MISS},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd1,  1'b1, ORIGIN},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd1,  5'd1,  1'b1, MISS},
    '{ROW_CFG,  REG_GRID_WIDTH,  1'b0, 5'd16, 5'd0,  1'b0, MISS},    // resize keeps cells
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd2,  5'd1,  1'b0, MISS},
    '{ROW_RECT, REG_GRID_WIDTH,  1'b0, 5'd16, 5'd1,  1'b0, MISS}
  };

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  reg_idx_t cfg_index;
  dim_t     cfg_data;

  ffgp_rect_if  rect_bus ();
  ffgp_place_if place_bus ();

  first_fit_grid_placer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rect_in   (rect_bus),
    .place_out (place_bus)
  );

  always #5 clk = ~clk;

  // Shadow of the block: occupancy grid and the two size registers.
  logic [NCOLS-1:0] occ_rows [NROWS];
  dim_t             grid_cols;
  dim_t             grid_rows;

  // Placements still owed by the block, oldest first.
  placement_t pending_places [$];

  int mismatches    = 0;
  int placed_seen   = 0;
  int rejected_seen = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;
  int ready_hold    = 0;

  // Scan anchors rows outer, columns inner; take the first one where the
  // rectangle stays inside the saturated grid over free cells, and mark it.
  function automatic placement_t first_fit(logic clr, dim_t w, dim_t h);
    int          gw, gh, wi, hi, x, y, r;
    logic [31:0] span;
    logic        hit;
    placement_t  res;
    res = MISS;
    gw  = (grid_cols > NCOLS) ? NCOLS : int'(grid_cols);
    gh  = (grid_rows > NROWS) ? NROWS : int'(grid_rows);
    wi  = int'(w);
    hi  = int'(h);
    if (clr) begin
      for (r = 0; r < NROWS; r++) occ_rows[r] = '0;
    end
    if (gw == 0 || gh == 0) return res;
    // Zero-size rectangle: placed at the origin, nothing marked.
    res.placed = 1'b1;
    if (wi == 0 || hi == 0) return res;
    span = (32'd1 << wi) - 32'd1;
    for (y = 0; y < gh; y++) begin
      for (x = 0; x < gw; x++) begin
        if (x + wi <= gw && y + hi <= gh) begin
          hit = 1'b0;
          for (r = y; r < y + hi; r++) hit |= |(32'(occ_rows[r]) & (span << x));
          if (!hit) begin
            for (r = y; r < y + hi; r++) occ_rows[r] |= NCOLS'(span << x);
            res.x = coord_t'(x);
            res.y = coord_t'(y);
            return res;
          end
        end
      end
    end
    return MISS;
  endfunction

  // Grid sizes: mostly in range, sometimes empty, single cell or past the top.
  function automatic dim_t pick_grid_dim();
    int unsigned r;
    r = $urandom_range(0, 39);
    case (r)
      0:       return dim_t'(0);
      1, 2:    return dim_t'(1);
      3, 4:    return dim_t'(16);
      5:       return dim_t'(31);
      6:       return dim_t'($urandom_range(17, 30));
      default: return dim_t'($urandom_range(2, 16));
    endcase
  endfunction

  // Sender gaps: mostly none, some short, a few long.
  function automatic int pick_gap(logic busy_run);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (busy_run || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one rectangle beat, hold it until accepted, then log what the
  // block owes for it. Valid stays high on return; the caller either sends
  // the next beat or drops valid in the same step.
  task automatic send_rect(logic clr, dim_t w, dim_t h, int gap, logic typed,
                           placement_t want);
    placement_t predicted;
    if (gap > 0) begin
      rect_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rect_bus.valid       <= 1'b1;
    rect_bus.clear_first <= clr;
    rect_bus.rect_width  <= w;
    rect_bus.rect_height <= h;
    do @(posedge clk); while (!rect_bus.ready);
    predicted = first_fit(clr, w, h);
    pending_places.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every owed placement has come back.
  task automatic settle();
    rect_bus.valid <= 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only on an idle block.
  task automatic write_reg(reg_idx_t idx, dim_t val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_WIDTH) grid_cols = val;
    else grid_rows = val;
    reg_writes++;
  endtask

  task automatic note_mismatch(string field, logic [3:0] want, logic [3:0] got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Receiver: ready held high or low for random stretches, mostly short
  // stalls, a few long ones, and now and then a long run with no stall.
  always @(posedge clk) begin
    int unsigned r;
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        place_bus.ready <= 1'b1;
        ready_hold = $urandom_range(1, 20);
      end else if (r < 90) begin
        place_bus.ready <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else if (r < 97) begin
        place_bus.ready <= 1'b0;
        ready_hold = $urandom_range(8, 40);
      end else begin
        place_bus.ready <= 1'b1;
        ready_hold = $urandom_range(100, 300);
      end
    end
  end

  // Compare every accepted placement beat with the oldest owed one.
  always @(posedge clk) begin
    placement_t want;
    if (!rst && place_bus.valid && place_bus.ready) begin
      if (place_bus.placed === 1'b1) placed_seen++;
      else rejected_seen++;
      if (pending_places.size() == 0) begin
        mismatches++;
        $error("placement beat with none owed: placed %0d x %0d y %0d",
               place_bus.placed, place_bus.cell_x, place_bus.cell_y);
      end else begin
        want = pending_places.pop_front();
        if (place_bus.placed !== want.placed) begin
          note_mismatch("placed", {3'b000, want.placed}, {3'b000, place_bus.placed});
        end
        if (place_bus.cell_x !== want.x) note_mismatch("cell_x", want.x, place_bus.cell_x);
        if (place_bus.cell_y !== want.y) note_mismatch("cell_y", want.y, place_bus.cell_y);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int   rand_rects, phase_len, i, gw, gh, kind;
    logic clr, busy_run, paused;
    dim_t w, h;

    // Drive every input to a known value before the first edge; the
    // receiver process owns ready from the first edge on.
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_GRID_WIDTH;
    cfg_data             <= '0;
    rect_bus.valid       <= 1'b0;
    rect_bus.clear_first <= 1'b0;
    rect_bus.rect_width  <= '0;
    rect_bus.rect_height <= '0;
    grid_cols = GRID_RESET;
    grid_rows = GRID_RESET;
    for (i = 0; i < NROWS; i++) occ_rows[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    for (i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_reg(DIRECTED[i].sel, DIRECTED[i].w);
      end else begin
        send_rect(DIRECTED[i].clr, DIRECTED[i].w, DIRECTED[i].h, pick_gap(1'b0),
                  DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random packing runs: each phase picks a grid size, opens with a
    // clearing beat, then packs mostly small rectangles so the grid fills
    // up and the scan has to search deep. Mixed in: full-size, oversize and
    // zero-size rectangles and the odd extra clear.
    rand_rects = 0;
    paused     = 1'b0;
    while (rand_rects < RANDOM_RECTS) begin
      write_reg(REG_GRID_WIDTH, pick_grid_dim());
      write_reg(REG_GRID_HEIGHT, pick_grid_dim());
      gw = (grid_cols > NCOLS) ? NCOLS : int'(grid_cols);
      gh = (grid_rows > NROWS) ? NROWS : int'(grid_rows);
      if (gw == 0) gw = 1;
      if (gh == 0) gh = 1;
      busy_run  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      for (i = 0; i < phase_len && rand_rects < RANDOM_RECTS; i++) begin
        // Halfway through, hold the sender until the block has drained.
        if (!paused && rand_rects >= RANDOM_RECTS / 2) begin
          settle();
          paused = 1'b1;
        end
        clr  = (i == 0) || ($urandom_range(0, 39) == 0);
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          w = dim_t'($urandom_range(0, 16));
          h = '0;
          if ($urandom_range(0, 1)) {w, h} = {h, w};
        end else if (kind == 1) begin
          w = dim_t'($urandom_range(0, 31));
          h = dim_t'($urandom_range(0, 31));
        end else if (kind < 6) begin
          w = dim_t'($urandom_range(1, gw));
          h = dim_t'($urandom_range(1, gh));
        end else begin
          w = dim_t'($urandom_range(1, (gw + 3) / 4));
          h = dim_t'($urandom_range(1, (gh + 3) / 4));
        end
        send_rect(clr, w, h, pick_gap(busy_run), 1'b0, MISS);
        rand_rects++;
      end
    end

    // Drain, then give the block time to show any stray beat.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d rectangles answered, %0d placed and %0d rejected",
             placed_seen + rejected_seen, placed_seen, rejected_seen);
    $display("summary: %0d register writes, grids from empty to saturated", reg_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### first_fit_grid_placer.f
design/ffgp_pkg.sv
design/ffgp_rect_if.sv
design/ffgp_place_if.sv
design/first_fit_grid_placer.sv
test/tb_first_fit_grid_placer.sv
